FILE: hdl/bpsd_pkg.sv
`default_nettype none

package bpsd_pkg;

  localparam int MAX_WIDTH_DEF     = 4096;
  localparam int MAX_HEIGHT_DEF    = 4096;
  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int QUEUE_DEPTH_DEF   = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int PIX_XW     = 12;
  localparam int PIX_YW     = 12;
  localparam int CNT_W      = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_DOWN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_RGB    = 3'd4;

  localparam logic [CNT_W-1:0] CH_ONE   = 3'd1;
  localparam logic [CNT_W-1:0] CH_THREE = 3'd3;
  localparam logic [CNT_W-1:0] CH_FOUR  = 3'd4;

  typedef enum logic [1:0] {
    FMT_1BPP  = 2'd0,
    FMT_8BPP  = 2'd1,
    FMT_24BPP = 2'd2,
    FMT_32BPP = 2'd3
  } pix_fmt_t;

  typedef enum logic [1:0] {
    OP_PAL_LOAD = 2'd0,
    OP_MONO     = 2'd1,
    OP_INDEX    = 2'd2,
    OP_DIRECT   = 2'd3
  } op_kind_t;

  // one queued operation: palette load uses byte_val as index and word[23:0] as entry;
  // direct pixels carry their channel bytes in word
  typedef struct packed {
    op_kind_t          kind;
    logic [7:0]        byte_val;
    logic [31:0]       word;
    logic [PIX_XW-1:0] x;
    logic [PIX_YW-1:0] y;
    logic [3:0]        run_len;
    logic              eoi;
    logic              wide;
  } work_item_t;

  typedef struct packed {
    logic force_rgb;
  } back_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/bpsd_fifo.sv
`default_nettype none

module bpsd_fifo
  import bpsd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire work_item_t push_item,
  output logic            full,
  output logic            head_valid,
  output work_item_t      head,
  input  wire logic       pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  work_item_t       slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/bpsd_front.sv
`default_nettype none

module bpsd_front
  import bpsd_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  mode,
  input  wire logic [7:0]            data_byte,
  input  wire logic [7:0]            pal_index,
  input  wire logic [7:0]            pal_byte0,
  input  wire logic [7:0]            pal_byte1,
  input  wire logic [7:0]            pal_byte2,
  output logic                       push,
  output work_item_t                 push_item,
  input  wire logic                  q_full,
  output back_ctrl_t                 ctrl
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int BW = WW + 2;

  pix_fmt_t               fmt;
  logic [CFG_DATA_W-1:0]  cfg_w;
  logic [CFG_DATA_W-1:0]  cfg_h;
  logic                   top_down;
  logic                   force_rgb;

  logic [BW-1:0]  byte_in_row, byte_in_row_next;
  logic [WW-1:0]  column_count, column_count_next;
  logic [HW-1:0]  row_count, row_count_next;
  logic [23:0]    partial_pixel, partial_pixel_next;
  logic [1:0]     partial_bytes, partial_bytes_next;

  logic [WW-1:0]  eff_w;
  logic [HW-1:0]  eff_h;
  logic [BW-1:0]  w_b, w3, stride, raw, bir_inc;
  logic [WW-1:0]  rem;
  logic [3:0]     mono_len;
  logic [WW-1:0]  col_plus1, col_plus_mono;
  logic           last_row;
  logic [HW-1:0]  y_full;
  logic [1:0]     need;
  logic           accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign ctrl.force_rgb = force_rgb;

  always_comb begin
    if (cfg_w == '0) begin
      eff_w = WW'(1);
    end else if (int'(cfg_w) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(cfg_w);
    end
    if (cfg_h == '0) begin
      eff_h = HW'(1);
    end else if (int'(cfg_h) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(cfg_h);
    end
  end

  // row stride is padded to a 32-bit boundary
  always_comb begin
    w_b = BW'(eff_w);
    w3  = (w_b << 1) + w_b;
    unique case (fmt)
      FMT_1BPP: begin
        stride = ((w_b + BW'(31)) >> 5) << 2;
        raw    = (w_b + BW'(7)) >> 3;
        need   = 2'd0;
      end
      FMT_8BPP: begin
        stride = ((w_b + BW'(3)) >> 2) << 2;
        raw    = w_b;
        need   = 2'd0;
      end
      FMT_24BPP: begin
        stride = ((w3 + BW'(3)) >> 2) << 2;
        raw    = w3;
        need   = 2'd2;
      end
      FMT_32BPP: begin
        stride = w_b << 2;
        raw    = w_b << 2;
        need   = 2'd3;
      end
      default: begin
        stride = w_b << 2;
        raw    = w_b << 2;
        need   = 2'd3;
      end
    endcase
  end

  always_comb begin
    rem           = eff_w - column_count;
    mono_len      = (rem >= WW'(8)) ? 4'd8 : 4'(rem);
    col_plus1     = column_count + WW'(1);
    col_plus_mono = column_count + WW'(mono_len);
    last_row      = ((row_count + HW'(1)) == eff_h);
    y_full        = top_down ? row_count : (eff_h - HW'(1) - row_count);
    bir_inc       = byte_in_row + BW'(1);
  end

  always_comb begin
    push               = 1'b0;
    push_item          = '0;
    push_item.x        = PIX_XW'(column_count);
    push_item.y        = PIX_YW'(y_full);
    push_item.byte_val = data_byte;
    push_item.run_len  = 4'd1;
    push_item.kind     = OP_INDEX;
    byte_in_row_next   = byte_in_row;
    column_count_next  = column_count;
    row_count_next     = row_count;
    partial_pixel_next = partial_pixel;
    partial_bytes_next = partial_bytes;

    if (!mode) begin
      push               = accept;
      push_item.kind     = OP_PAL_LOAD;
      push_item.byte_val = pal_index;
      push_item.word     = {8'h00, pal_byte2, pal_byte1, pal_byte0};
    end else begin
      if (byte_in_row < raw) begin
        unique case (fmt)
          FMT_1BPP: begin
            push              = accept;
            push_item.kind    = OP_MONO;
            push_item.run_len = mono_len;
            push_item.eoi     = last_row && (col_plus_mono == eff_w);
            column_count_next = col_plus_mono;
          end
          FMT_8BPP: begin
            push              = accept;
            push_item.kind    = OP_INDEX;
            push_item.eoi     = last_row && (col_plus1 == eff_w);
            column_count_next = col_plus1;
          end
          default: begin
            if (partial_bytes >= need) begin
              push           = accept;
              push_item.kind = OP_DIRECT;
              push_item.eoi  = last_row && (col_plus1 == eff_w);
              push_item.wide = (fmt == FMT_32BPP);
              if (fmt == FMT_32BPP) begin
                push_item.word = {data_byte, partial_pixel};
              end else begin
                push_item.word = {8'h00, data_byte, partial_pixel[15:0]};
              end
              column_count_next  = col_plus1;
              partial_pixel_next = '0;
              partial_bytes_next = '0;
            end else begin
              unique case (partial_bytes)
                2'd0:    partial_pixel_next[7:0]   = data_byte;
                2'd1:    partial_pixel_next[15:8]  = data_byte;
                2'd2:    partial_pixel_next[23:16] = data_byte;
                default: partial_pixel_next        = partial_pixel;
              endcase
              partial_bytes_next = partial_bytes + 2'd1;
            end
          end
        endcase
      end

      byte_in_row_next = bir_inc;
      if (bir_inc >= stride) begin
        byte_in_row_next   = '0;
        column_count_next  = '0;
        partial_pixel_next = '0;
        partial_bytes_next = '0;
        row_count_next     = ((row_count + HW'(1)) >= eff_h) ? '0 : row_count + HW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt           <= FMT_24BPP;
      cfg_w         <= CFG_DATA_W'(1);
      cfg_h         <= CFG_DATA_W'(1);
      top_down      <= 1'b0;
      force_rgb     <= 1'b1;
      byte_in_row   <= '0;
      column_count  <= '0;
      row_count     <= '0;
      partial_pixel <= '0;
      partial_bytes <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PIXEL_FORMAT: fmt       <= pix_fmt_t'(cfg_data[1:0]);
        CFG_IMAGE_WIDTH:  cfg_w     <= cfg_data;
        CFG_IMAGE_HEIGHT: cfg_h     <= cfg_data;
        CFG_TOP_DOWN:     top_down  <= cfg_data[0];
        CFG_FORCE_RGB:    force_rgb <= cfg_data[0];
        default: ;
      endcase
      if (cfg_index == CFG_PIXEL_FORMAT || cfg_index == CFG_IMAGE_WIDTH ||
          cfg_index == CFG_IMAGE_HEIGHT) begin
        byte_in_row   <= '0;
        column_count  <= '0;
        row_count     <= '0;
        partial_pixel <= '0;
        partial_bytes <= '0;
      end
    end else if (accept && mode) begin
      byte_in_row   <= byte_in_row_next;
      column_count  <= column_count_next;
      row_count     <= row_count_next;
      partial_pixel <= partial_pixel_next;
      partial_bytes <= partial_bytes_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/bpsd_back.sv
`default_nettype none

module bpsd_back
  import bpsd_pkg::*;
#(
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         head_valid,
  input  wire work_item_t   head,
  output logic              pop,
  input  wire back_ctrl_t   ctrl,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [PIX_XW-1:0] pixel_x,
  output logic [PIX_YW-1:0] pixel_y,
  output logic [7:0]        chan0,
  output logic [7:0]        chan1,
  output logic [7:0]        chan2,
  output logic [7:0]        chan3,
  output logic [CNT_W-1:0]  channel_count,
  output logic              last_of_run,
  output logic              end_of_image
);

  localparam int PAW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic [23:0]              pal_mem [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] pal_vld;
  logic                     gray_flag;
  logic [2:0]               bit_idx;

  logic                     advance;
  logic                     mono_bit;
  logic [7:0]               rd_idx;
  logic                     idx_ok;
  logic [PAW-1:0]           mem_addr;
  logic                     mono_last;
  logic                     item_last;
  logic                     is_load;
  logic                     entry_gray;

  // output stage
  op_kind_t                 o_kind;
  logic [PIX_XW-1:0]        o_x;
  logic [PIX_YW-1:0]        o_y;
  logic [31:0]              o_word;
  logic                     o_wide;
  logic                     o_single;
  logic                     o_last;
  logic                     o_eoi;
  logic [23:0]              pal_q;
  logic                     pal_q_ok;
  logic [23:0]              entry;

  assign advance    = !out_valid || out_ready;
  assign is_load    = (head.kind == OP_PAL_LOAD);
  assign mono_bit   = head.byte_val[3'd7 - bit_idx];
  assign rd_idx     = is_load ? head.byte_val :
                      (head.kind == OP_MONO) ? {7'd0, mono_bit} : head.byte_val;
  assign idx_ok     = (int'(rd_idx) < PALETTE_DEPTH);
  assign mem_addr   = PAW'(rd_idx);
  assign mono_last  = ((4'(bit_idx) + 4'd1) == head.run_len);
  assign item_last  = (head.kind != OP_MONO) || mono_last;
  assign pop        = head_valid && advance && item_last;
  assign entry_gray = (head.word[7:0] == head.word[15:8]) &&
                      (head.word[15:8] == head.word[23:16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      bit_idx   <= '0;
      gray_flag <= 1'b1;
      pal_vld   <= '0;
    end else if (advance) begin
      if (head_valid) begin
        if (is_load) begin
          out_valid <= 1'b0;
          if (idx_ok) begin
            pal_vld[mem_addr] <= 1'b1;
            gray_flag <= (head.byte_val == 8'd0) ? entry_gray : (gray_flag && entry_gray);
          end
        end else begin
          out_valid <= 1'b1;
          if (head.kind == OP_MONO) begin
            bit_idx <= mono_last ? '0 : bit_idx + 3'd1;
          end
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && head_valid) begin
      if (is_load) begin
        if (idx_ok) begin
          pal_mem[mem_addr] <= head.word[23:0];
        end
      end else begin
        pal_q    <= pal_mem[mem_addr];
        pal_q_ok <= idx_ok && pal_vld[mem_addr];
        o_kind   <= head.kind;
        o_x      <= head.x + PIX_XW'(bit_idx);
        o_y      <= head.y;
        o_word   <= head.word;
        o_wide   <= head.wide;
        o_single <= (head.kind == OP_INDEX) && gray_flag && !ctrl.force_rgb;
        o_last   <= item_last;
        o_eoi    <= head.eoi && item_last;
      end
    end
  end

  // entries never loaded since reset read as zero
  assign entry = pal_q_ok ? pal_q : 24'd0;

  always_comb begin
    pixel_x      = o_x;
    pixel_y      = o_y;
    last_of_run  = o_last;
    end_of_image = o_eoi;
    unique case (o_kind)
      OP_DIRECT: begin
        chan0         = o_word[7:0];
        chan1         = o_word[15:8];
        chan2         = o_word[23:16];
        chan3         = o_wide ? o_word[31:24] : 8'd0;
        channel_count = o_wide ? CH_FOUR : CH_THREE;
      end
      OP_MONO, OP_INDEX: begin
        chan0         = entry[7:0];
        chan1         = o_single ? 8'd0 : entry[15:8];
        chan2         = o_single ? 8'd0 : entry[23:16];
        chan3         = 8'd0;
        channel_count = o_single ? CH_ONE : CH_THREE;
      end
      default: begin
        chan0         = 8'd0;
        chan1         = 8'd0;
        chan2         = 8'd0;
        chan3         = 8'd0;
        channel_count = CH_THREE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/bmp_pixel_stream_decoder_core.sv
`default_nettype none

// Bitmap pixel-array decoder for 1, 8, 24 and 32 bpp uncompressed images. Feed palette
// entries (mode 0) and then the padded pixel array one byte per transfer (mode 1); row
// padding bytes produce nothing. Each output transfer is one pixel with its column, its
// destination row (flipped unless top_down) and 1, 3 or 4 channel bytes in stored order.
// The input takes one byte per cycle while the queue has room; a 1bpp byte yields up to
// eight pixels, one per cycle while out_ready is high, so the one-pixel-per-transfer
// output sets 1bpp throughput. A four-entry queue separates byte classification from pixel
// output, so a stalled output side still absorbs a few bytes. Write configuration only
// while the decoder is idle; changing format, width or height restarts the stream position.
module bmp_pixel_stream_decoder_core
  import bpsd_pkg::*;
#(
  parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT    = MAX_HEIGHT_DEF,
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  mode,
  input  wire logic [7:0]            data_byte,
  input  wire logic [7:0]            pal_index,
  input  wire logic [7:0]            pal_byte0,
  input  wire logic [7:0]            pal_byte1,
  input  wire logic [7:0]            pal_byte2,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [PIX_XW-1:0]          pixel_x,
  output logic [PIX_YW-1:0]          pixel_y,
  output logic [7:0]                 chan0,
  output logic [7:0]                 chan1,
  output logic [7:0]                 chan2,
  output logic [7:0]                 chan3,
  output logic [CNT_W-1:0]           channel_count,
  output logic                       last_of_run,
  output logic                       end_of_image
);

  logic       push;
  work_item_t push_item;
  logic       q_full;
  logic       head_valid;
  work_item_t head;
  logic       pop;
  back_ctrl_t ctrl;

  bpsd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .data_byte (data_byte),
    .pal_index (pal_index),
    .pal_byte0 (pal_byte0),
    .pal_byte1 (pal_byte1),
    .pal_byte2 (pal_byte2),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full),
    .ctrl      (ctrl)
  );

  bpsd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  bpsd_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .ctrl          (ctrl),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .chan0         (chan0),
    .chan1         (chan1),
    .chan2         (chan2),
    .chan3         (chan3),
    .channel_count (channel_count),
    .last_of_run   (last_of_run),
    .end_of_image  (end_of_image)
  );

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`default_nettype none

module tb_top;
  import bpsd_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int SETTLE      = 64;
  localparam int WATCHDOG    = 4000;
  localparam int HOLD_CYCLES = 300;

  localparam logic MODE_PALETTE = 1'b0;
  localparam logic MODE_PIXEL   = 1'b1;
  localparam int   LAST_CFG_IDX = (1 << CFG_IDX_W) - 1;

  typedef struct packed {
    logic [PIX_XW-1:0] x;
    logic [PIX_YW-1:0] y;
    logic [7:0]        c0;
    logic [7:0]        c1;
    logic [7:0]        c2;
    logic [7:0]        c3;
    logic [CNT_W-1:0]  n;
    logic              last;
    logic              eoi;
  } pixel_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_ready;
  logic mode;
  logic [7:0] data_byte, pal_index, pal_byte0, pal_byte1, pal_byte2;
  logic out_valid, out_ready;
  logic [PIX_XW-1:0] pixel_x;
  logic [PIX_YW-1:0] pixel_y;
  logic [7:0] chan0, chan1, chan2, chan3;
  logic [CNT_W-1:0] channel_count;
  logic last_of_run, end_of_image;

  bmp_pixel_stream_decoder_core DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .data_byte(data_byte),
    .pal_index(pal_index), .pal_byte0(pal_byte0), .pal_byte1(pal_byte1),
    .pal_byte2(pal_byte2),
    .out_valid(out_valid), .out_ready(out_ready), .pixel_x(pixel_x), .pixel_y(pixel_y),
    .chan0(chan0), .chan1(chan1), .chan2(chan2), .chan3(chan3),
    .channel_count(channel_count), .last_of_run(last_of_run), .end_of_image(end_of_image)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // decoder shadow state
  pix_fmt_t r_fmt;
  logic [CFG_DATA_W-1:0] r_width, r_height;
  logic r_top_down, r_force_rgb;
  logic [23:0] pal_mem [256];
  logic gray_pal;
  int unsigned row_byte, col_pos, row_pos, acc_cnt;
  logic [23:0] acc_pix;

  pixel_t pending_pixels[$];

  int mismatches = 0;
  int sent_items = 0;
  bit tx_gaps, rx_gaps;
  int rx_hold_req = 0;
  int rx_hold_left = 0;
  int rx_stall_left = 0;
  int quiet_cycles = 0;

  function automatic int unsigned eff_dim(logic [CFG_DATA_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (32'(v) > lim) return lim;
    return 32'(v);
  endfunction

  function automatic int unsigned bits_per_pixel(pix_fmt_t f);
    case (f)
      FMT_1BPP:  return 1;
      FMT_8BPP:  return 8;
      FMT_24BPP: return 24;
      default:   return 32;
    endcase
  endfunction

  function automatic int unsigned row_stride(pix_fmt_t f, logic [CFG_DATA_W-1:0] w);
    return ((eff_dim(w, MAX_WIDTH_DEF) * bits_per_pixel(f) + 31) / 32) * 4;
  endfunction

  function automatic void restart_position();
    row_byte = 0;
    col_pos = 0;
    row_pos = 0;
    acc_pix = '0;
    acc_cnt = 0;
  endfunction

  function automatic void reset_model();
    r_fmt = FMT_24BPP;
    r_width = 1;
    r_height = 1;
    r_top_down = 1'b0;
    r_force_rgb = 1'b1;
    foreach (pal_mem[i]) pal_mem[i] = '0;
    gray_pal = 1'b1;
    restart_position();
  endfunction

  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] v);
    case (idx)
      CFG_PIXEL_FORMAT: begin
        r_fmt = pix_fmt_t'(v[1:0]);
        restart_position();
      end
      CFG_IMAGE_WIDTH: begin
        r_width = v;
        restart_position();
      end
      CFG_IMAGE_HEIGHT: begin
        r_height = v;
        restart_position();
      end
      CFG_TOP_DOWN:  r_top_down = v[0];
      CFG_FORCE_RGB: r_force_rgb = v[0];
      default: ;
    endcase
  endfunction

  function automatic void load_palette_entry(logic [7:0] idx, logic [7:0] b0, logic [7:0] b1,
                                             logic [7:0] b2);
    logic eq;
    eq = (b0 == b1) && (b1 == b2);
    pal_mem[idx] = {b2, b1, b0};
    // index 0 starts a new palette, so the grayscale test starts over
    gray_pal = (idx == 8'd0) ? eq : (gray_pal & eq);
  endfunction

  function automatic void push_pixel(int unsigned w, int unsigned h, logic [7:0] c0,
                                     logic [7:0] c1, logic [7:0] c2, logic [7:0] c3,
                                     logic [CNT_W-1:0] n, logic last);
    pixel_t p;
    int unsigned yv;
    yv = r_top_down ? row_pos : h - 1 - row_pos;
    p.x = col_pos[PIX_XW-1:0];
    p.y = yv[PIX_YW-1:0];
    p.c0 = c0;
    p.c1 = c1;
    p.c2 = c2;
    p.c3 = c3;
    p.n = n;
    p.last = last;
    p.eoi = (row_pos + 1 == h) && (col_pos + 1 == w);
    pending_pixels.push_back(p);
    col_pos++;
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    int unsigned w, h, bpp, stride, raw, need;
    int bit_pos;
    logic [23:0] e;
    w = eff_dim(r_width, MAX_WIDTH_DEF);
    h = eff_dim(r_height, MAX_HEIGHT_DEF);
    bpp = bits_per_pixel(r_fmt);
    stride = row_stride(r_fmt, r_width);
    raw = (bpp == 1) ? (w + 7) / 8 : w * (bpp / 8);
    if (row_byte < raw) begin
      case (r_fmt)
        FMT_1BPP: begin
          for (bit_pos = 7; bit_pos >= 0 && col_pos < w; bit_pos--) begin
            e = pal_mem[{7'd0, b[bit_pos]}];
            push_pixel(w, h, e[7:0], e[15:8], e[23:16], 8'd0, CH_THREE,
                       (bit_pos == 0) || (col_pos + 1 >= w));
          end
        end
        FMT_8BPP: begin
          e = pal_mem[b];
          if (gray_pal && !r_force_rgb) push_pixel(w, h, e[7:0], 8'd0, 8'd0, 8'd0, CH_ONE, 1'b1);
          else push_pixel(w, h, e[7:0], e[15:8], e[23:16], 8'd0, CH_THREE, 1'b1);
        end
        default: begin
          need = bpp / 8 - 1;
          if (acc_cnt >= need) begin
            if (bpp == 24) push_pixel(w, h, acc_pix[7:0], acc_pix[15:8], b, 8'd0, CH_THREE, 1'b1);
            else push_pixel(w, h, acc_pix[7:0], acc_pix[15:8], acc_pix[23:16], b, CH_FOUR, 1'b1);
            acc_pix = '0;
            acc_cnt = 0;
          end else begin
            acc_pix[8*acc_cnt +: 8] = b;
            acc_cnt++;
          end
        end
      endcase
    end
    row_byte++;
    if (row_byte >= stride) begin
      row_byte = 0;
      col_pos = 0;
      acc_pix = '0;
      acc_cnt = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
  endtask

  // predicts on every accepted input and config transfer, checks every output transfer
  always @(posedge clk) begin : monitor
    pixel_t want;
    if (rst) begin
      reset_model();
    end else begin
      if (cfg_valid && cfg_ready) apply_reg_write(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        if (mode == MODE_PALETTE) load_palette_entry(pal_index, pal_byte0, pal_byte1, pal_byte2);
        else decode_byte(data_byte);
      end
      if (out_valid && out_ready) begin
        if (pending_pixels.size() == 0) begin
          report_mismatch($sformatf("pixel (%0d,%0d) with none expected", pixel_x, pixel_y));
        end else begin
          want = pending_pixels.pop_front();
          check_field("pixel_x", 16'(pixel_x), 16'(want.x));
          check_field("pixel_y", 16'(pixel_y), 16'(want.y));
          check_field("chan0", 16'(chan0), 16'(want.c0));
          check_field("chan1", 16'(chan1), 16'(want.c1));
          check_field("chan2", 16'(chan2), 16'(want.c2));
          check_field("chan3", 16'(chan3), 16'(want.c3));
          check_field("channel_count", 16'(channel_count), 16'(want.n));
          check_field("last_of_run", 16'(last_of_run), 16'(want.last));
          check_field("end_of_image", 16'(end_of_image), 16'(want.eoi));
        end
      end
    end
  end

  always @(posedge clk) begin : rx_drive
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_hold_req > 0) begin
        rx_hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (rx_hold_left > 0) begin
        out_ready <= 1'b0;
        rx_hold_left--;
      end else if (rx_stall_left > 0) begin
        out_ready <= 1'b0;
        rx_stall_left--;
      end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        rx_stall_left = $urandom_range(1, 13) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG) begin
      $display("bmp_pixel_stream_decoder_core regression: fail");
      $finish;
    end
  end

  task automatic send_item(logic m, logic [7:0] d, logic [7:0] idx, logic [7:0] b0,
                           logic [7:0] b1, logic [7:0] b2);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    data_byte <= d;
    pal_index <= idx;
    pal_byte0 <= b0;
    pal_byte1 <= b1;
    pal_byte2 <= b2;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_pal(logic [7:0] idx, logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
    send_item(MODE_PALETTE, 8'($urandom), idx, b0, b1, b2);
  endtask

  // unused palette fields carry noise
  task automatic send_byte(logic [7:0] b);
    send_item(MODE_PIXEL, b, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // stop sending, wait for every pixel, then let trailing padding/palette work finish
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // cfg_valid stays high across back-to-back writes; caller lowers it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // upper data bits of the format and flag writes are noise; the block keeps only the low bits
  task automatic configure(pix_fmt_t f, logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                           bit td, bit frgb);
    drain();
    write_reg(CFG_PIXEL_FORMAT, CFG_DATA_W'(($urandom & 32'h1FFC) | f));
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_TOP_DOWN, CFG_DATA_W'(($urandom & 32'h1FFE) | td));
    write_reg(CFG_FORCE_RGB, CFG_DATA_W'(($urandom & 32'h1FFE) | frgb));
    write_reg(CFG_IDX_W'($urandom_range(CFG_FORCE_RGB + 1, LAST_CFG_IDX)),
              CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed();
    // 1bpp, 3 columns: five bits of each byte fall past the row, 3 pad bytes per row
    configure(FMT_1BPP, 3, 2, 0, 1);
    send_pal(8'd0, 8'h00, 8'h00, 8'h00);
    send_pal(8'd1, 8'hFF, 8'hFF, 8'hFF);
    send_byte(8'hA5);
    repeat (3) send_byte(8'hFF);
    send_byte(8'h5A);
    repeat (3) send_byte(8'h00);
    // 8bpp gray single channel until a non-gray entry; width 0 acts as 1, height saturates, top-down
    configure(FMT_8BPP, 0, 8191, 1, 0);
    send_pal(8'd7, 8'h80, 8'h80, 8'h80);
    send_byte(8'd7);
    repeat (3) send_byte(8'h00);
    send_pal(8'd255, 8'h12, 8'h34, 8'h56);
    send_byte(8'd255);
    repeat (3) send_byte(8'hFF);
    send_pal(8'd0, 8'h40, 8'h40, 8'h40);
    send_byte(8'd0);
    // 24bpp: width saturates, height 0 acts as 1
    configure(FMT_24BPP, 8191, 0, 0, 1);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    // 32bpp one-pixel image, wraps to row 0 after the row
    configure(FMT_32BPP, 1, 1, 1, 0);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
  endtask

  task automatic test_random_images(int budget);
    int first, total, i, k, n;
    pix_fmt_t f;
    logic [CFG_DATA_W-1:0] w, h;
    logic [7:0] idx, g;
    bit wide;
    first = sent_items;
    while (sent_items - first < budget) begin
      f = pix_fmt_t'($urandom_range(0, 3));
      wide = ($urandom_range(0, 7) == 0);
      w = wide ? CFG_DATA_W'($urandom_range(1000, 8191)) : CFG_DATA_W'($urandom_range(0, 6));
      h = wide ? CFG_DATA_W'($urandom) : CFG_DATA_W'($urandom_range(0, 3));
      configure(f, w, h, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      if (f == FMT_1BPP || f == FMT_8BPP) begin
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) begin
          idx = (k == 0) ? 8'd0 : 8'($urandom_range(0, 15));
          g = 8'($urandom);
          if ($urandom_range(0, 2) != 0) send_pal(idx, g, g, g);
          else send_pal(idx, 8'($urandom), 8'($urandom), 8'($urandom));
        end
      end
      // wide rows are only started; the next configure restarts the position
      total = wide ? $urandom_range(8, 24)
                   : row_stride(f, w) * eff_dim(h, MAX_HEIGHT_DEF) + $urandom_range(0, 3);
      for (i = 0; i < total; i++) begin
        case ($urandom_range(0, 39))
          0: send_pal(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
          1: begin
            // view flags change mid-image once the decoder is idle
            drain();
            if ($urandom_range(0, 1)) write_reg(CFG_TOP_DOWN, CFG_DATA_W'($urandom));
            else write_reg(CFG_FORCE_RGB, CFG_DATA_W'($urandom));
            cfg_valid <= 1'b0;
            @(posedge clk);
          end
          default: ;
        endcase
        if (f == FMT_8BPP && $urandom_range(0, 1)) send_byte(8'($urandom_range(0, 15)));
        else send_byte(8'($urandom));
      end
    end
  endtask

  // hold the output side off while bytes keep coming, so the input stalls
  task automatic test_output_stall();
    int i;
    configure(FMT_8BPP, 16, 2, 0, 1);
    tx_gaps = 1'b0;
    rx_hold_req = HOLD_CYCLES;
    for (i = 0; i < 40; i++) send_byte(8'($urandom));
    tx_gaps = 1'b1;
    drain();
  endtask

  task automatic test_quiet_tail();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    test_random_images(40);
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    mode = MODE_PALETTE;
    data_byte = '0;
    pal_index = '0;
    pal_byte0 = '0;
    pal_byte1 = '0;
    pal_byte2 = '0;
    out_ready = 1'b0;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_images(170);
    test_output_stall();
    test_quiet_tail();
    drain();
    if (mismatches == 0)
      $display("bmp_pixel_stream_decoder_core regression: pass");
    else
      $display("bmp_pixel_stream_decoder_core regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
hdl/bpsd_pkg.sv
hdl/bpsd_fifo.sv
hdl/bpsd_front.sv
hdl/bpsd_back.sv
hdl/bmp_pixel_stream_decoder_core.sv
sim/tb_top.sv
